// File: rtl/windowed_average_timing_defines.svh
// assertion macros for the windowed average block
`ifndef WINDOWED_AVERAGE_TIMING_DEFINES_SVH
`define WINDOWED_AVERAGE_TIMING_DEFINES_SVH

// same-cycle implication, off during reset
`define WAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define WAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked through reset as well
`define WAT_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/wat_pkg.sv
package wat_pkg;

  // default sizing
  localparam int WINDOW_MAX_DEF  = 128;
  localparam int SAMPLE_BITS_DEF = 32;

  // register reset and field widths
  localparam int LEN_RESET = 100;
  localparam int CFG_BITS  = 8;
  localparam int IN_BITS   = 32;
  localparam int AVG_BITS  = 32;
  localparam int SUM_BITS  = 39;
  localparam int LAST_BITS = 32;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/wat_channels.sv
// sample request channel
interface wat_in_if;
  logic                          valid;
  logic                          ready;
  logic [wat_pkg::IN_BITS-1:0]   elapsed_us;

  modport source (output valid, output elapsed_us, input ready);
  modport sink   (input valid, input elapsed_us, output ready);
endinterface

// result request channel
interface wat_out_if;
  logic                          valid;
  logic                          ready;
  logic [wat_pkg::AVG_BITS-1:0]  average_us;
  logic [wat_pkg::SUM_BITS-1:0]  window_sum;
  logic [wat_pkg::LAST_BITS-1:0] last_us;

  modport source (output valid, output average_us, output window_sum, output last_us,
                  input ready);
  modport sink   (input valid, input average_us, input window_sum, input last_us,
                  output ready);
endinterface

// File: rtl/windowed_average_timing.sv
// windowed average of timing samples
// in_ch carries one elapsed_us sample per request; out_ch returns one result
// per sample: the truncated mean, the window sum and the sample just stored.
// cfg_we/cfg_wdata write the window length (0 reads as 1, above WINDOW_MAX
// reads as WINDOW_MAX) and restart the window; write it only while idle.
// the first sample after reset or a length write fills the whole window.
// samples live in a one-port-read ring memory with a fill count, so slots
// not yet rewritten read as the first sample without a clearing pass.
// an accepted sample goes through one memory read, one update, then the
// bit-serial divider producing one quotient bit per cycle, into the result.
// one sample is in flight at a time: no new sample is taken until the
// result for the last one has been written to the output register.
// a finished result sits in the output register; the next sample is taken
// while it waits, and a new result waits until the receiver takes the old one.
// reset (rst, synchronous) restores length 100 and an empty window.
module windowed_average_timing #(
  parameter int WINDOW_MAX  = wat_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = wat_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [wat_pkg::CFG_BITS-1:0] cfg_wdata,
  wat_in_if.sink                       in_ch,
  wat_out_if.source                    out_ch
);

  localparam int SLOT_BITS  = $clog2(WINDOW_MAX);
  localparam int LEN_BITS   = $clog2(WINDOW_MAX + 1);
  localparam int TOTAL_BITS = SAMPLE_BITS + SLOT_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_START,
    S_DIV,
    S_OUT
  } state_t;

  state_t                        state;
  logic [LEN_BITS-1:0]           length;
  logic [SLOT_BITS-1:0]          slot;
  logic [LEN_BITS-1:0]           fill;
  logic                          started;
  logic [SAMPLE_BITS-1:0]        fill_value;
  logic [SAMPLE_BITS-1:0]        sample;
  logic [TOTAL_BITS-1:0]         total;
  logic [SAMPLE_BITS-1:0]        rdata;
  logic [TOTAL_BITS-1:0]         quotient;
  wat_pkg::div_stat_t            div_stat;
  logic                          out_valid;
  logic [wat_pkg::AVG_BITS-1:0]  avg_q;
  logic [wat_pkg::SUM_BITS-1:0]  sum_q;
  logic [wat_pkg::LAST_BITS-1:0] last_q;

  logic [LEN_BITS-1:0]           slot_inc;
  logic [SLOT_BITS-1:0]          slot_next;
  logic [SAMPLE_BITS-1:0]        old_sample;
  logic [TOTAL_BITS-1:0]         fill_total;
  logic [TOTAL_BITS-1:0]         total_next;
  logic                          in_req;

  // clamp a written length into 1..WINDOW_MAX
  function automatic logic [LEN_BITS-1:0] clamp_len(input logic [wat_pkg::CFG_BITS-1:0] v);
    logic [LEN_BITS-1:0] r;
    if (v == '0) begin
      r = LEN_BITS'(1);
    end else if (32'(v) > WINDOW_MAX) begin
      r = LEN_BITS'(WINDOW_MAX);
    end else begin
      r = LEN_BITS'(v);
    end
    return r;
  endfunction

  // ring memory of samples
  wat_ram #(
    .DEPTH (WINDOW_MAX),
    .WIDTH (SAMPLE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (state == S_READ),
    .waddr (slot),
    .wdata (sample),
    .raddr (slot),
    .rdata (rdata)
  );

  // mean of the window
  wat_div #(
    .N (TOTAL_BITS),
    .D (LEN_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .dividend (total),
    .divisor  (length),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign in_req = in_ch.valid && in_ch.ready;

  // slot advance, oldest sample and new sum
  always_comb begin
    slot_inc   = LEN_BITS'(slot) + LEN_BITS'(1);
    slot_next  = (slot_inc >= length) ? '0 : SLOT_BITS'(slot_inc);
    old_sample = (LEN_BITS'(slot) < fill) ? rdata : fill_value;
    fill_total = TOTAL_BITS'(sample) * TOTAL_BITS'(length);
    total_next = total - TOTAL_BITS'(old_sample) + TOTAL_BITS'(sample);
  end

  // sequencer, window state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= clamp_len(wat_pkg::CFG_BITS'(wat_pkg::LEN_RESET));
      slot      <= '0;
      fill      <= '0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        length  <= clamp_len(cfg_wdata);
        slot    <= '0;
        fill    <= '0;
        started <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_req) begin
            sample <= SAMPLE_BITS'(in_ch.elapsed_us);
            state  <= S_READ;
          end
        end
        S_READ: begin
          // first sample fills the window, later ones replace the oldest
          if (!started) begin
            started    <= 1'b1;
            fill_value <= sample;
            fill       <= LEN_BITS'(1);
            total      <= fill_total;
          end else begin
            total <= total_next;
            if (fill != length) begin
              fill <= fill + LEN_BITS'(1);
            end
          end
          slot  <= slot_next;
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            avg_q     <= wat_pkg::AVG_BITS'(quotient);
            sum_q     <= wat_pkg::SUM_BITS'(total);
            last_q    <= wat_pkg::LAST_BITS'(sample);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state == S_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.average_us = avg_q;
  assign out_ch.window_sum = sum_q;
  assign out_ch.last_us    = last_q;

endmodule

// File: rtl/wat_ram.sv
module wat_ram #(
  parameter int DEPTH = wat_pkg::WINDOW_MAX_DEF,
  parameter int WIDTH = wat_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/wat_div.sv
module wat_div #(
  parameter int N = 39,
  parameter int D = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [N-1:0]       dividend,
  input  logic [D-1:0]       divisor,
  output logic [N-1:0]       quotient,
  output wat_pkg::div_stat_t stat
);

  localparam int CNT_BITS = $clog2(N + 1);

  logic [D-1:0]        rem;
  logic [D-1:0]        dvs;
  logic [N-1:0]        quo;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic                done;
  logic [D:0]          trial;
  logic [D:0]          diff;
  logic                fits;

  // restoring step, one quotient bit per cycle
  always_comb begin
    trial = {rem, quo[N-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= CNT_BITS'(N);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? diff[D-1:0] : trial[D-1:0];
        quo <= {quo[N-2:0], fits};
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: rtl/wat_checker.sv
`include "windowed_average_timing_defines.svh"

module wat_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [wat_pkg::AVG_BITS-1:0]  average_us,
  input logic [wat_pkg::SUM_BITS-1:0]  window_sum
);

  // a stalled result stays offered
  `WAT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // one sample in flight: no request taken right after another
  `WAT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "sample taken while busy")

  // the mean never exceeds the window sum
  `WAT_ASSERT_IMP(a_mean_bound, out_valid, wat_pkg::SUM_BITS'(average_us) <= window_sum, "mean above sum")

  // reset empties the output register
  `WAT_ASSERT_NEXT_RST(a_reset_out, rst, !out_valid, "result valid after reset")

endmodule

bind windowed_average_timing wat_checker u_wat_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .average_us (out_ch.average_us),
  .window_sum (out_ch.window_sum)
);

// File: tb/windowed_average_timing_tb.sv
module windowed_average_timing_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = wat_pkg::WINDOW_MAX_DEF;
  localparam int DRAIN_WAIT = 60;

  typedef struct packed {
    logic [wat_pkg::AVG_BITS-1:0]  avg;
    logic [wat_pkg::SUM_BITS-1:0]  sum;
    logic [wat_pkg::LAST_BITS-1:0] last;
  } window_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [wat_pkg::CFG_BITS-1:0] cfg_wdata = '0;

  wat_in_if  in_ch();
  wat_out_if out_ch();

  windowed_average_timing u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state: ring, running sum, slot, fill flag, length
  logic [wat_pkg::IN_BITS-1:0]  win_store [DEPTH];
  logic [wat_pkg::SUM_BITS-1:0] win_total;
  int                           win_slot;
  bit                           win_started;
  int                           win_len;

  window_result_t pending_results [$];
  int             err_count = 0;
  int             samples_sent = 0;

  // sender pacing and receiver hold-off
  int burst_left = 0;
  int recv_hold_req = 0;
  int recv_hold_left = 0;
  logic [31:0] recv_pattern = '1;
  int recv_pat_pos = 0;
  int recv_pat_count = 0;

  always #6 clk = ~clk;

  function automatic int clamp_window(logic [wat_pkg::CFG_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > DEPTH) return DEPTH;
    return int'(v);
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < DEPTH; i++) win_store[i] = '0;
    win_total   = '0;
    win_slot    = 0;
    win_started = 1'b0;
  endfunction

  // ring update and truncating mean for one sample
  function automatic window_result_t predict_average(logic [wat_pkg::IN_BITS-1:0] sample);
    window_result_t r;
    int slot;
    slot = win_slot;
    if (slot >= win_len) slot = 0;
    if (!win_started) begin
      // first sample fills the whole window
      win_started = 1'b1;
      for (int i = 0; i < win_len; i++) win_store[i] = sample;
      win_total = wat_pkg::SUM_BITS'(sample) * wat_pkg::SUM_BITS'(win_len);
    end else begin
      win_total = win_total - wat_pkg::SUM_BITS'(win_store[slot])
                  + wat_pkg::SUM_BITS'(sample);
      win_store[slot] = sample;
    end
    slot++;
    if (slot >= win_len) slot = 0;
    win_slot = slot;
    r.avg  = wat_pkg::AVG_BITS'(win_total / wat_pkg::SUM_BITS'(win_len));
    r.sum  = win_total;
    r.last = sample;
    return r;
  endfunction

  // offer one sample request and wait for it to be taken
  task automatic send_sample(logic [wat_pkg::IN_BITS-1:0] sample);
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.elapsed_us <= sample;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_average(sample));
    samples_sent++;
  endtask

  task automatic sender_gap(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // bursts of random length, random gaps between them
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 9) < 3) sender_gap(0);
      else sender_gap($urandom_range(1, 60));
    end
    burst_left--;
  endtask

  // hold the sender off until every result has come back
  task automatic wait_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_length(logic [wat_pkg::CFG_BITS-1:0] v);
    wait_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    win_len = clamp_window(v);
    clear_window();
  endtask

  function automatic logic [wat_pkg::IN_BITS-1:0] random_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $urandom_range(0, 1000);
      6:          return '1;
      7:          return '0;
      8:          return $urandom | 32'hFFF0_0000;
      default:    return 32'hFFFF_FFFF - $urandom_range(0, 15);
    endcase
  endfunction

  // receiver: own stall pattern, plus a long hold-off when asked
  always @(negedge clk) begin
    if (recv_hold_req != 0) begin
      recv_hold_left = recv_hold_req;
      recv_hold_req  = 0;
    end
    if (recv_hold_left > 0) begin
      recv_hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (recv_pat_count == 0) begin
        recv_pat_count = $urandom_range(16, 200);
        case ($urandom_range(0, 3))
          0: recv_pattern = '1;
          1: recv_pattern = $urandom;
          2: recv_pattern = $urandom | $urandom;
          default: recv_pattern = $urandom & $urandom;
        endcase
      end
      out_ch.ready <= recv_pattern[recv_pat_pos];
      recv_pat_pos = (recv_pat_pos + 1) % 32;
      recv_pat_count--;
    end
  end

  // compare each result request with the oldest prediction
  always @(posedge clk) begin : check_results
    window_result_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result avg=%0d sum=%0d last=%0d", $time,
                 out_ch.average_us, out_ch.window_sum, out_ch.last_us);
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.average_us !== exp_r.avg) begin
          $display("%0t: average_us expected %0d actual %0d", $time,
                   exp_r.avg, out_ch.average_us);
          err_count++;
        end
        if (out_ch.window_sum !== exp_r.sum) begin
          $display("%0t: window_sum expected %0d actual %0d", $time,
                   exp_r.sum, out_ch.window_sum);
          err_count++;
        end
        if (out_ch.last_us !== exp_r.last) begin
          $display("%0t: last_us expected %0d actual %0d", $time,
                   exp_r.last, out_ch.last_us);
          err_count++;
        end
      end
    end
  end

  // default length after reset, first sample fills the window
  task automatic test_reset_window();
    send_sample(32'd1000);
    send_sample(32'd2000);
    send_sample(32'hFFFF_FFFF);
  endtask

  // largest and smallest windows with extreme samples
  task automatic test_window_extremes();
    write_length(8'd128);
    repeat (3) send_sample(32'hFFFF_FFFF);
    repeat (2) send_sample(32'h0000_0000);
    write_length(8'd1);
    send_sample(32'd5);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'd0);
    write_length(8'd2);
    send_sample(32'd7);
    send_sample(32'd8);
    send_sample(32'd9);
  endtask

  // length zero reads as one, above the maximum reads as the maximum
  task automatic test_length_clamp();
    write_length(8'd0);
    send_sample(32'd123);
    send_sample(32'd456);
    write_length(8'hFF);
    send_sample(32'hDEAD_BEEF);
    send_sample(32'd1);
    write_length(8'd129);
    send_sample(32'h8000_0000);
  endtask

  // long receiver hold-off while samples keep coming
  task automatic test_output_backpressure();
    write_length(8'd3);
    @(posedge clk);
    recv_hold_req = 400;
    for (int i = 0; i < 8; i++) send_sample(random_sample());
    wait_drain();
  endtask

  // random lengths and samples with random pacing
  task automatic test_random_windows(int count);
    int n;
    int target;
    logic [wat_pkg::CFG_BITS-1:0] len_code;
    target = samples_sent + count;
    while (samples_sent < target) begin
      case ($urandom_range(0, 9))
        0: len_code = 8'd128;
        1: len_code = 8'd0;
        2: len_code = 8'hFF;
        3: len_code = $urandom_range(0, 255);
        4: len_code = 8'd1;
        default: len_code = $urandom_range(2, 20);
      endcase
      write_length(len_code);
      n = $urandom_range(10, 90);
      if (n > target - samples_sent) n = target - samples_sent;
      for (int i = 0; i < n; i++) begin
        send_sample(random_sample());
        if ($urandom_range(0, 199) == 0) wait_drain();
        else pace_sender();
      end
    end
    write_length(8'd100);
    for (int i = 0; i < 20; i++) begin
      send_sample(random_sample());
      pace_sender();
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.elapsed_us = '0;
    out_ch.ready     = 1'b0;
    win_len = clamp_window(wat_pkg::CFG_BITS'(wat_pkg::LEN_RESET));
    clear_window();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_window();
    test_window_extremes();
    test_length_clamp();
    test_output_backpressure();
    test_random_windows(1500);

    wait_drain();
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
